// ----- design/bss_pkg.sv -----
// Package for the base similarity scorer: widths, register indexes, reset values
// and the command/status structs between controller and datapath.
// No dependencies.
package bss_pkg;

    localparam int C_BASE_W  = 2;
    localparam int C_CNT_W   = 8;
    localparam int C_PCT_W   = 7;
    localparam int C_NUM_W   = 15;
    localparam int C_STEP_W  = 3;
    localparam int C_CFG_W   = 8;
    localparam int C_IDX_W   = 1;

    localparam logic [C_PCT_W-1:0]  C_PERCENT_SCALE = 7'd100;
    localparam logic [C_PCT_W-1:0]  C_SIM_RESET     = 7'd75;
    localparam logic [C_CNT_W-1:0]  C_RUN_RESET     = 8'd15;
    localparam logic [C_STEP_W-1:0] C_TOP_STEP      = 3'd6;

    localparam logic [C_IDX_W-1:0] C_REG_SIM_THR = 1'b0;
    localparam logic [C_IDX_W-1:0] C_REG_RUN_THR = 1'b1;

    typedef struct packed {
        logic count_en;
        logic start_div;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

// ----- design/bss_ctrl.sv -----
// Controller of the base similarity scorer: counting, dividing, result states.
// Depends on bss_pkg.
module bss_ctrl
    import bss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_base,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_COUNT = 3'b001,
        ST_DIV   = 3'b010,
        ST_OUT   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Pairs that are not last keep counting in every state; a last pair waits
    // until the divider and the result register are free.
    assign o_in_stall  = (r_state != ST_COUNT) && i_last_base;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        n_state         = r_state;
        o_cmd.count_en  = accept;
        o_cmd.start_div = 1'b0;
        o_cmd.div_step  = 1'b0;
        unique case (r_state)
            ST_COUNT: begin
                if (accept && i_last_base) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_COUNT;
                end
            end
            default: begin
                n_state = ST_COUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/bss_datapath.sv -----
// Datapath of the base similarity scorer: pair counters, threshold registers,
// a restoring divider one quotient bit per cycle, and the result registers.
// Depends on bss_pkg.
module bss_datapath
    import bss_pkg::*;
#(
    parameter int MAX_LEN = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [C_BASE_W-1:0] i_ref_base,
    input  logic [C_BASE_W-1:0] i_probe_base,
    input  logic                i_cfg_we,
    input  logic [C_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_W-1:0]  i_cfg_data,
    output t_dp_sts             o_sts,
    output logic [C_PCT_W-1:0]  o_similarity_percent,
    output logic [C_CNT_W-1:0]  o_longest_run,
    output logic                o_is_hit,
    output logic                o_length_overflow
);

    localparam logic [C_CNT_W-1:0] C_MAX = C_CNT_W'(MAX_LEN);

    logic [C_CNT_W-1:0]  r_pair, r_match, r_run, r_best;
    logic                r_ovf;
    logic [C_CNT_W-1:0]  n_pair, n_match, n_run, n_best;
    logic                n_ovf;
    logic [C_CNT_W-1:0]  cnt_pair, cnt_match, cnt_run, cnt_best;
    logic                cnt_ovf;

    logic [C_PCT_W-1:0]  r_sim_thr;
    logic [C_CNT_W-1:0]  r_run_thr;

    logic [C_NUM_W-1:0]  r_rem;
    logic [C_CNT_W-1:0]  r_div;
    logic [C_PCT_W-1:0]  r_quo;
    logic [C_STEP_W-1:0] r_step;
    logic [C_CNT_W-1:0]  r_best_snap;
    logic                r_ovf_snap;
    logic [C_NUM_W-1:0]  shifted;

    // Counter update for one accepted pair.
    always_comb begin
        cnt_pair  = r_pair;
        cnt_match = r_match;
        cnt_run   = r_run;
        cnt_best  = r_best;
        cnt_ovf   = r_ovf;
        if (i_cmd.count_en) begin
            if (r_pair >= C_MAX) begin
                cnt_ovf = 1'b1;
            end else begin
                cnt_pair = r_pair + 1'b1;
                if (i_ref_base == i_probe_base) begin
                    cnt_match = r_match + 1'b1;
                    cnt_run   = r_run + 1'b1;
                    if (cnt_run > r_best) begin
                        cnt_best = cnt_run;
                    end
                end else begin
                    cnt_run = '0;
                end
            end
        end
    end

    // The last pair of a probe hands its totals to the divider and clears.
    always_comb begin
        if (i_cmd.start_div) begin
            n_pair  = '0;
            n_match = '0;
            n_run   = '0;
            n_best  = '0;
            n_ovf   = 1'b0;
        end else begin
            n_pair  = cnt_pair;
            n_match = cnt_match;
            n_run   = cnt_run;
            n_best  = cnt_best;
            n_ovf   = cnt_ovf;
        end
    end

    assign shifted        = C_NUM_W'(r_div) << r_step;
    assign o_sts.div_last = (r_step == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair    <= '0;
            r_match   <= '0;
            r_run     <= '0;
            r_best    <= '0;
            r_ovf     <= 1'b0;
            r_sim_thr <= C_SIM_RESET;
            r_run_thr <= C_RUN_RESET;
        end else begin
            r_pair  <= n_pair;
            r_match <= n_match;
            r_run   <= n_run;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    C_REG_SIM_THR: r_sim_thr <= i_cfg_data[C_PCT_W-1:0];
                    C_REG_RUN_THR: r_run_thr <= i_cfg_data;
                    default:       r_run_thr <= r_run_thr;
                endcase
            end
        end
    end

    // The quotient never exceeds 100, so seven trial subtractions suffice.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_rem       <= C_NUM_W'(C_PERCENT_SCALE) * C_NUM_W'(cnt_match);
            r_div       <= cnt_pair;
            r_quo       <= '0;
            r_step      <= C_TOP_STEP;
            r_best_snap <= cnt_best;
            r_ovf_snap  <= cnt_ovf;
        end else if (i_cmd.div_step) begin
            if (r_rem >= shifted) begin
                r_rem         <= r_rem - shifted;
                r_quo[r_step] <= 1'b1;
            end
            r_step <= r_step - 1'b1;
        end
    end

    assign o_similarity_percent = r_quo;
    assign o_longest_run        = r_best_snap;
    assign o_length_overflow    = r_ovf_snap;
    assign o_is_hit             = (r_quo >= r_sim_thr) || (r_best_snap >= r_run_thr);

endmodule

// ----- design/base_similarity_scorer.sv -----
// Top level of the base similarity scorer: controller plus datapath.
// Depends on bss_pkg, bss_ctrl and bss_datapath.
//
// Usage: one aligned base pair (genome base, probe base) arrives per input
// beat on i_in_valid / o_in_stall; i_last_base marks the final pair of a probe.
// For each probe the block emits one result beat on o_out_valid / i_out_stall
// carrying floor(100*matches/pairs), the longest run of matches, the hit flag
// and a flag telling that the probe ran past MAX_LEN pairs (only the first
// MAX_LEN pairs are scored then).
// Throughput: one pair per cycle within a probe. The result is set by the restoring divider,
// which starts at the edge that accepts the last pair and produces one quotient bit per cycle.
// Pairs of the next probe are accepted while the division runs and while a
// result waits; only that probe's last pair is stalled until the previous
// result beat has been taken. A stalled result simply stays on the outputs.
// Thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data while the
// block is idle. Reset (synchronous, active low) clears all counters, drops
// o_out_valid and restores the thresholds to 75 percent and a run of 15.
module base_similarity_scorer
    import bss_pkg::*;
#(
    parameter int MAX_LEN = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [C_BASE_W-1:0] i_ref_base,
    input  logic [C_BASE_W-1:0] i_probe_base,
    input  logic                i_last_base,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [C_PCT_W-1:0]  o_similarity_percent,
    output logic [C_CNT_W-1:0]  o_longest_run,
    output logic                o_is_hit,
    output logic                o_length_overflow,
    input  logic                i_cfg_we,
    input  logic [C_IDX_W-1:0]  i_cfg_idx,
    input  logic [C_CFG_W-1:0]  i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller sequences counting, the divider steps and the result beat.
    bss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_base (i_last_base),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // The datapath holds counters, thresholds, the divider and result registers.
    bss_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_ref_base           (i_ref_base),
        .i_probe_base         (i_probe_base),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_sts                (sts),
        .o_similarity_percent (o_similarity_percent),
        .o_longest_run        (o_longest_run),
        .o_is_hit             (o_is_hit),
        .o_length_overflow    (o_length_overflow)
    );

endmodule

// ----- design/bss_checker.sv -----
// Port-level checker for the base similarity scorer, bound to the top level.
// Depends on bss_pkg.
module bss_checker
    import bss_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                i_last_base,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [C_PCT_W-1:0]  o_similarity_percent,
    input logic [C_CNT_W-1:0]  o_longest_run
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_similarity_percent <= C_PERCENT_SCALE)
        else $error("similarity above 100 percent");

    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_base |=> !o_out_valid)
        else $error("result appeared before the division finished");

    a_full_match_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_similarity_percent == C_PERCENT_SCALE) |-> o_longest_run != '0)
        else $error("full similarity with an empty run");

endmodule

bind base_similarity_scorer bss_checker u_bss_checker (.*);

// ----- tb/sv/base_similarity_scorer_tb.sv -----
// Self-checking testbench for base_similarity_scorer: directed probes from a table, then
// random probes under four idling phases, scored by an in-bench predictor unless a row gives the result.
// Depends on bss_pkg and the base_similarity_scorer RTL.
module base_similarity_scorer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    localparam int MAX_LEN        = 128;
    localparam int RESET_CYCLES   = 8;
    // Cycles to wait, once every owed score is out, before touching the threshold registers
    // or ending the run.
    localparam int DRAIN_CYCLES   = 12;
    // No correct run goes this long without a beat on either channel.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 390;
    localparam int N_PHASES       = 4;
    localparam int MAX_REPORTS    = 10;

    // One scored probe, laid out in the order of the result ports.
    typedef struct packed {
        logic [C_PCT_W-1:0] pct;
        logic [C_CNT_W-1:0] run;
        logic               hit;
        logic               ovf;
    } t_score;

    typedef enum logic {ROW_PAIRS, ROW_REG} t_row_kind;

    // A directed row is either a run of identical pairs or a threshold write. When
    // the row closes a probe and typed is set, want is the result read straight off
    // the specification; otherwise the predictor supplies it.
    typedef struct {
        t_row_kind            kind;
        int                   count;
        logic [C_BASE_W-1:0]  rb;
        logic [C_BASE_W-1:0]  pb;
        logic                 last;
        logic                 typed;
        t_score               want;
        logic [C_IDX_W-1:0]   idx;
        logic [C_CFG_W-1:0]   data;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [C_BASE_W-1:0] i_ref_base = '0;
    logic [C_BASE_W-1:0] i_probe_base = '0;
    logic                i_last_base = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [C_PCT_W-1:0]  o_similarity_percent;
    logic [C_CNT_W-1:0]  o_longest_run;
    logic                o_is_hit;
    logic                o_length_overflow;
    logic                i_cfg_we = 1'b0;
    logic [C_IDX_W-1:0]  i_cfg_idx = '0;
    logic [C_CFG_W-1:0]  i_cfg_data = '0;

    base_similarity_scorer #(.MAX_LEN(MAX_LEN)) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_ref_base           (i_ref_base),
        .i_probe_base         (i_probe_base),
        .i_last_base          (i_last_base),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_similarity_percent (o_similarity_percent),
        .o_longest_run        (o_longest_run),
        .o_is_hit             (o_is_hit),
        .o_length_overflow    (o_length_overflow),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: a private copy of the thresholds and of the per-probe counters.
    logic [C_PCT_W-1:0] sim_thr = C_SIM_RESET;
    logic [C_CNT_W-1:0] run_thr = C_RUN_RESET;
    logic [C_CNT_W-1:0] pairs_seen = '0;
    logic [C_CNT_W-1:0] matches_seen = '0;
    logic [C_CNT_W-1:0] run_now = '0;
    logic [C_CNT_W-1:0] run_best = '0;
    logic               past_max = 1'b0;

    // Scores still owed by the block, oldest first.
    t_score pending_scores[$];
    t_row   directed_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pairs_sent     = 0;
    int probes_sent    = 0;
    int scores_checked = 0;
    int fail_count     = 0;

    function automatic void note_failure(string what, t_score want, t_score got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $write("%0t: %s: expected pct=%0d run=%0d hit=%0b ovf=%0b, ",
                   $realtime, what, want.pct, want.run, want.hit, want.ovf);
            $display("got pct=%0d run=%0d hit=%0b ovf=%0b",
                     got.pct, got.run, got.hit, got.ovf);
        end
    endfunction

    // Advances the predictor by one accepted pair. On the closing pair of a probe it
    // produces the score and clears the counters for the next probe.
    task automatic score_pair(input logic [C_BASE_W-1:0] rb, input logic [C_BASE_W-1:0] pb,
                              input logic last, output logic produced, output t_score res);
        int pct;
        produced = 1'b0;
        res = '0;
        // Once MAX_LEN pairs are in, further pairs only raise the overflow flag.
        if (pairs_seen >= MAX_LEN) begin
            past_max = 1'b1;
        end else begin
            pairs_seen++;
            if (rb == pb) begin
                matches_seen++;
                run_now++;
                if (run_now > run_best) begin
                    run_best = run_now;
                end
            end else begin
                run_now = '0;
            end
        end
        if (last) begin
            // Either the closing pair is counted or MAX_LEN pairs already are, so pairs_seen is never zero.
            pct = (100 * int'(matches_seen)) / int'(pairs_seen);
            res.pct = pct[C_PCT_W-1:0];
            res.run = run_best;
            res.hit = (res.pct >= sim_thr) || (run_best >= run_thr);
            res.ovf = past_max;
            produced = 1'b1;
            pairs_seen = '0;
            matches_seen = '0;
            run_now = '0;
            run_best = '0;
            past_max = 1'b0;
        end
    endtask

    // Offers one pair, with random idle cycles in front of it, and holds it until the
    // block takes it. The expected score is queued at the accepting edge.
    task automatic send_pair(input logic [C_BASE_W-1:0] rb, input logic [C_BASE_W-1:0] pb,
                             input logic last, input logic typed, input t_score want);
        logic   produced;
        t_score res;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_ref_base   <= rb;
        i_probe_base <= pb;
        i_last_base  <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        score_pair(rb, pb, last, produced, res);
        pairs_sent++;
        if (produced) begin
            probes_sent++;
            pending_scores.push_back(typed ? want : res);
        end
    endtask

    // Drops valid, waits for every owed score, then lets the divider run out.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_scores.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One write beat, then the enable goes low before anything else is done.
    task automatic write_reg(input logic [C_IDX_W-1:0] idx, input logic [C_CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == C_REG_SIM_THR) begin
            sim_thr = data[C_PCT_W-1:0];
        end else begin
            run_thr = data;
        end
        @(posedge i_clk);
    endtask

    task automatic add_pairs(input int n, input logic [C_BASE_W-1:0] rb,
                             input logic [C_BASE_W-1:0] pb, input logic last,
                             input logic typed, input t_score want);
        t_row r;
        r = '{kind: ROW_PAIRS, count: n, rb: rb, pb: pb, last: last, typed: typed,
              want: want, idx: '0, data: '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_reg(input logic [C_IDX_W-1:0] idx, input logic [C_CFG_W-1:0] data);
        t_row r;
        r = '{kind: ROW_REG, count: 0, rb: '0, pb: '0, last: 1'b0, typed: 1'b0,
              want: '0, idx: idx, data: data};
        directed_rows.push_back(r);
    endtask

    // Random probes until the phase has sent its share of pairs. Most probes are
    // short; a tenth run up to MAX_LEN and a few past it. Each probe gets its own
    // match rate so that similarity and run length spread over their whole range,
    // and a sprinkling of fully random pairs adds noise.
    task automatic run_probes(input int budget);
        int                  start;
        int                  len;
        int                  match_pct;
        int                  sel;
        int                  k;
        logic [C_BASE_W-1:0] rb;
        logic [C_BASE_W-1:0] pb;
        start = pairs_sent;
        while (pairs_sent - start < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                len = $urandom_range(1, 24);
            end else if (sel < 95) begin
                len = $urandom_range(25, MAX_LEN);
            end else begin
                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 20);
            end
            match_pct = $urandom_range(0, 100);
            for (k = 0; k < len; k++) begin
                rb = C_BASE_W'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) begin
                    pb = C_BASE_W'($urandom_range(0, 3));
                end else if ($urandom_range(0, 99) < match_pct) begin
                    pb = rb;
                end else begin
                    pb = rb ^ C_BASE_W'($urandom_range(1, 3));
                end
                send_pair(rb, pb, k == len - 1, 1'b0, '0);
            end
        end
    endtask

    // Result side: take a beat whenever one is offered and not stalled, compare it
    // with the oldest owed score, then pick the stall for the next cycle.
    always @(posedge i_clk) begin : score_check
        t_score got;
        t_score want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_similarity_percent, o_longest_run, o_is_hit, o_length_overflow};
                scores_checked++;
                if (pending_scores.size() == 0) begin
                    note_failure("result beat with no score owed", '0, got);
                end else begin
                    want = pending_scores.pop_front();
                    if (got !== want) begin
                        note_failure("score mismatch", want, got);
                    end
                end
            end
            i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d scores still owed",
                     $realtime, quiet_cycles, pending_scores.size());
            $display("base_similarity_scorer_tb NOT OK");
            $finish;
        end
    end

    initial begin : main
        t_row r;
        int   k;
        int   phase;

        // Directed probes under the reset thresholds (75 percent, run of 15).
        add_pairs(1, 2'd0, 2'd0, 1'b1, 1'b1, '{7'd100, 8'd1, 1'b1, 1'b0});
        add_pairs(1, 2'd3, 2'd0, 1'b1, 1'b1, '{7'd0, 8'd0, 1'b0, 1'b0});
        add_pairs(15, 2'd3, 2'd3, 1'b1, 1'b1, '{7'd100, 8'd15, 1'b1, 1'b0});
        add_pairs(3, 2'd0, 2'd1, 1'b0, 1'b0, '0);
        add_pairs(1, 2'd2, 2'd2, 1'b1, 1'b1, '{7'd25, 8'd1, 1'b0, 1'b0});
        // Overflow where only the closing pair lands past MAX_LEN; it must not count.
        add_pairs(MAX_LEN, 2'd1, 2'd1, 1'b0, 1'b0, '0);
        add_pairs(1, 2'd0, 2'd3, 1'b1, 1'b1, '{7'd100, 8'd128, 1'b1, 1'b1});
        // Overflow on a probe that never matches.
        add_pairs(MAX_LEN + 2, 2'd2, 2'd1, 1'b1, 1'b1, '{7'd0, 8'd0, 1'b0, 1'b1});
        // Mixed probes: a broken run, left to the predictor.
        add_pairs(2, 2'd0, 2'd0, 1'b0, 1'b0, '0);
        add_pairs(1, 2'd1, 2'd2, 1'b0, 1'b0, '0);
        add_pairs(3, 2'd3, 2'd3, 1'b1, 1'b0, '0);
        add_pairs(2, 2'd1, 2'd1, 1'b0, 1'b0, '0);
        add_pairs(5, 2'd2, 2'd0, 1'b0, 1'b0, '0);
        add_pairs(1, 2'd3, 2'd3, 1'b1, 1'b0, '0);
        // Similarity threshold above 100: only the run threshold can make a hit.
        add_reg(C_REG_SIM_THR, 8'h7f);
        add_pairs(20, 2'd1, 2'd1, 1'b1, 1'b1, '{7'd100, 8'd20, 1'b1, 1'b0});
        add_pairs(1, 2'd2, 2'd2, 1'b1, 1'b1, '{7'd100, 8'd1, 1'b0, 1'b0});
        // Run threshold of zero: every probe is a hit.
        add_reg(C_REG_RUN_THR, 8'd0);
        add_pairs(1, 2'd0, 2'd2, 1'b1, 1'b1, '{7'd0, 8'd0, 1'b1, 1'b0});
        // Similarity threshold of zero with the largest run threshold.
        add_reg(C_REG_SIM_THR, 8'd0);
        add_reg(C_REG_RUN_THR, 8'hff);
        add_pairs(1, 2'd1, 2'd3, 1'b1, 1'b1, '{7'd0, 8'd0, 1'b1, 1'b0});
        // Similarity threshold at exactly 100.
        add_reg(C_REG_SIM_THR, 8'd100);
        add_pairs(3, 2'd0, 2'd0, 1'b0, 1'b0, '0);
        add_pairs(1, 2'd1, 2'd0, 1'b1, 1'b1, '{7'd75, 8'd3, 1'b0, 1'b0});
        add_pairs(2, 2'd3, 2'd3, 1'b1, 1'b1, '{7'd100, 8'd2, 1'b1, 1'b0});

        // Single reset pulse at the start; the block comes up with its reset thresholds.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table with no idling on either side. A threshold write
        // waits until every owed score is out and the divider has gone quiet.
        foreach (directed_rows[n]) begin
            r = directed_rows[n];
            if (r.kind == ROW_REG) begin
                wait_quiet();
                write_reg(r.idx, r.data);
            end else begin
                for (k = 0; k < r.count; k++) begin
                    send_pair(r.rb, r.pb, r.last && (k == r.count - 1),
                              r.typed && (k == r.count - 1), r.want);
                end
            end
        end

        // Random probes. Each phase starts from an idle block, sets its thresholds
        // and its idling pattern: none, sender idle, receiver stalling, then both.
        for (phase = 0; phase < N_PHASES; phase++) begin
            wait_quiet();
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_reg(C_REG_SIM_THR, C_CFG_W'($urandom_range(0, 100)));
                    write_reg(C_REG_RUN_THR, C_CFG_W'($urandom_range(0, 40)));
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                    write_reg(C_REG_SIM_THR, 8'd100);
                    write_reg(C_REG_RUN_THR, 8'hff);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                    write_reg(C_REG_SIM_THR, 8'd0);
                    write_reg(C_REG_RUN_THR, 8'd0);
                end
                default: begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                    // Full 8-bit data: the similarity register keeps its low 7 bits.
                    write_reg(C_REG_SIM_THR, C_CFG_W'($urandom_range(0, 255)));
                    write_reg(C_REG_RUN_THR, C_CFG_W'($urandom_range(0, 255)));
                end
            endcase
            run_probes(ITEMS_PER_PHASE);
        end

        wait_quiet();
        $display("Sent %0d base pairs in %0d probes over %0d idling phases; %0d scores checked.",
                 pairs_sent, probes_sent, N_PHASES, scores_checked);
        $display("Failures: %0d", fail_count);
        if (fail_count == 0) begin
            $display("base_similarity_scorer_tb OK");
        end else begin
            $display("base_similarity_scorer_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/bss_pkg.sv
design/bss_ctrl.sv
design/bss_datapath.sv
design/base_similarity_scorer.sv
design/bss_checker.sv
tb/sv/base_similarity_scorer_tb.sv
